FILE: rtl/core/fpcd_pkg.sv
// Shared constants, types and coefficient tables of the five-point difference block.
`timescale 1ns / 1ps

package fpcd_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_BITS  = 32;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned DERIV_BITS   = 48;
  localparam int unsigned SCALE_BITS   = 48;
  localparam int unsigned NUM_TAPS     = 5;
  localparam int unsigned NUM_ROWS     = 4;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned COEF_BITS    = 6;

  // Dot product and magnitude widths.
  localparam int unsigned NUM_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned MAG_BITS = NUM_BITS - 1;

  // The scale is multiplied in two halves.
  localparam int unsigned SCALE_LO_BITS = SCALE_BITS / 2;
  localparam int unsigned SCALE_HI_BITS = SCALE_BITS - SCALE_LO_BITS;
  localparam int unsigned PP_LO_BITS    = MAG_BITS + SCALE_LO_BITS;
  localparam int unsigned PP_HI_BITS    = MAG_BITS + SCALE_HI_BITS;
  localparam int unsigned PROD_BITS     = MAG_BITS + SCALE_BITS + 1;

  // Division by three through a reciprocal. It is exact for every dividend below
  // 2^QIN_BITS because QIN_BITS is odd and the reciprocal is (2^QIN_BITS + 1) / 3.
  localparam int unsigned QIN_BITS      = DERIV_BITS + 1;
  localparam int unsigned RECIP_BITS    = QIN_BITS - 1;
  localparam int unsigned QIN_LO_BITS   = (QIN_BITS + 1) / 2;
  localparam int unsigned QIN_HI_BITS   = QIN_BITS - QIN_LO_BITS;
  localparam int unsigned RECIP_LO_BITS = RECIP_BITS / 2;
  localparam int unsigned RECIP_HI_BITS = RECIP_BITS - RECIP_LO_BITS;
  localparam int unsigned PLL_BITS      = QIN_LO_BITS + RECIP_LO_BITS;
  localparam int unsigned PLH_BITS      = QIN_LO_BITS + RECIP_HI_BITS;
  localparam int unsigned PHL_BITS      = QIN_HI_BITS + RECIP_LO_BITS;
  localparam int unsigned PHH_BITS      = QIN_HI_BITS + RECIP_HI_BITS;
  localparam int unsigned QPROD_BITS    = QIN_BITS + RECIP_BITS;

  localparam logic [RECIP_BITS-1:0] RECIP_THIRD =
    RECIP_BITS'(((128'd1 << QIN_BITS) + 128'd1) / 128'd3);

  // Scale value 1.0 after reset.
  localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << FRAC_BITS;

  // Clipping bounds, as magnitudes and as output patterns.
  localparam logic [DERIV_BITS-1:0] LIMIT_POS = (DERIV_BITS'(1) << (DERIV_BITS - 1)) - 1'b1;
  localparam logic [DERIV_BITS-1:0] LIMIT_NEG = DERIV_BITS'(1) << (DERIV_BITS - 1);

  // Derivative rows; the row code is also the index of its scale register.
  typedef enum logic [1:0] {
    ROW_FIRST  = 2'd0,
    ROW_SECOND = 2'd1,
    ROW_THIRD  = 2'd2,
    ROW_FOURTH = 2'd3
  } row_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_FIRST  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_SECOND = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_THIRD  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_FOURTH = CFG_IDX_BITS'(3);

  // Stencil weights, taps ordered from two left to two right.
  localparam logic signed [COEF_BITS-1:0] COEF [NUM_ROWS][NUM_TAPS] = '{
    '{ 6'sd1,  -6'sd8,   6'sd0,  6'sd8,  -6'sd1},
    '{-6'sd1,   6'sd16, -6'sd30, 6'sd16, -6'sd1},
    '{-6'sd1,   6'sd2,   6'sd0, -6'sd2,   6'sd1},
    '{ 6'sd1,  -6'sd4,   6'sd6, -6'sd4,   6'sd1}
  };

  // Row denominators: the power-of-two part becomes a shift, and rows in
  // THIRD_ROWS also divide by three.
  localparam int unsigned ROW_DEN     [NUM_ROWS] = '{12, 12, 2, 1};
  localparam int unsigned ROUND_SHIFT [NUM_ROWS] = '{FRAC_BITS + 2, FRAC_BITS + 2,
                                                     FRAC_BITS + 1, FRAC_BITS};
  localparam logic [NUM_ROWS-1:0] THIRD_ROWS = 4'b0011;

  // Pipeline stages.
  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned ST_NUM = 0;
  localparam int unsigned ST_MAG = 1;
  localparam int unsigned ST_PP  = 2;
  localparam int unsigned ST_RND = 3;
  localparam int unsigned ST_QPP = 4;
  localparam int unsigned ST_QUO = 5;
  localparam int unsigned ST_OUT = 6;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctrl_t;

  // Half of the full divisor, added before truncation to round to nearest.
  function automatic logic [PROD_BITS-1:0] round_half(row_e row);
    return (PROD_BITS'(ROW_DEN[row]) << FRAC_BITS) >> 1;
  endfunction

endpackage

FILE: rtl/core/fpcd_stencil.sv
// Stencil dot products and their sign and magnitude, two register stages.
`timescale 1ns / 1ps

module fpcd_stencil (
  input  logic                                   clk_i,
  input  fpcd_pkg::pipe_ctrl_t                   ctrl_i,
  input  logic signed [fpcd_pkg::SAMPLE_BITS-1:0] sample_i [fpcd_pkg::NUM_TAPS],
  output logic        [fpcd_pkg::MAG_BITS-1:0]    mag_o    [fpcd_pkg::NUM_ROWS],
  output logic        [fpcd_pkg::NUM_ROWS-1:0]    neg_o
);

  logic signed [fpcd_pkg::NUM_BITS-1:0] num_d [fpcd_pkg::NUM_ROWS];
  logic signed [fpcd_pkg::NUM_BITS-1:0] num_q [fpcd_pkg::NUM_ROWS];
  logic signed [fpcd_pkg::NUM_BITS-1:0] abs_d [fpcd_pkg::NUM_ROWS];
  logic        [fpcd_pkg::MAG_BITS-1:0] mag_q [fpcd_pkg::NUM_ROWS];
  logic        [fpcd_pkg::NUM_ROWS-1:0] neg_d;
  logic        [fpcd_pkg::NUM_ROWS-1:0] neg_q;

  // Weights are small constants, so each term is a few shifted adds.
  always_comb begin
    for (int r = 0; r < fpcd_pkg::NUM_ROWS; r++) begin
      num_d[r] = '0;
      for (int t = 0; t < fpcd_pkg::NUM_TAPS; t++) begin
        num_d[r] = num_d[r] + fpcd_pkg::NUM_BITS'(sample_i[t])
                            * fpcd_pkg::NUM_BITS'(fpcd_pkg::COEF[r][t]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < fpcd_pkg::NUM_ROWS; r++) begin
      neg_d[r] = num_q[r][fpcd_pkg::NUM_BITS-1];
      abs_d[r] = neg_d[r] ? -num_q[r] : num_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[fpcd_pkg::ST_NUM]) begin
      num_q <= num_d;
    end
    if (ctrl_i.en[fpcd_pkg::ST_MAG]) begin
      neg_q <= neg_d;
      for (int r = 0; r < fpcd_pkg::NUM_ROWS; r++) begin
        mag_q[r] <= abs_d[r][fpcd_pkg::MAG_BITS-1:0];
      end
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

FILE: rtl/core/fpcd_deriv.sv
// One derivative row: scale multiply, rounding, optional division by three and saturation.
`timescale 1ns / 1ps

module fpcd_deriv (
  input  logic                                    clk_i,
  input  fpcd_pkg::pipe_ctrl_t                    ctrl_i,
  input  fpcd_pkg::row_e                          row_i,
  input  logic        [fpcd_pkg::MAG_BITS-1:0]    mag_i,
  input  logic                                    neg_i,
  input  logic        [fpcd_pkg::SCALE_BITS-1:0]  scale_i,
  output logic signed [fpcd_pkg::DERIV_BITS-1:0]  deriv_o,
  output logic                                    sat_o
);

  // Scale multiply in two partial products.
  logic [fpcd_pkg::PP_LO_BITS-1:0] pp_lo_q;
  logic [fpcd_pkg::PP_HI_BITS-1:0] pp_hi_q;
  logic                            neg3_q;

  // Rounded and shifted product.
  logic [fpcd_pkg::PROD_BITS-1:0]  prod_d;
  logic [fpcd_pkg::PROD_BITS-1:0]  shifted_d;
  logic [fpcd_pkg::QIN_BITS-1:0]   qin4_q;
  logic                            big4_q;
  logic                            neg4_q;

  // Reciprocal partial products.
  logic [fpcd_pkg::QIN_LO_BITS-1:0] qin_lo;
  logic [fpcd_pkg::QIN_HI_BITS-1:0] qin_hi;
  logic [fpcd_pkg::PLL_BITS-1:0]    pll_q;
  logic [fpcd_pkg::PLH_BITS-1:0]    plh_q;
  logic [fpcd_pkg::PHL_BITS-1:0]    phl_q;
  logic [fpcd_pkg::PHH_BITS-1:0]    phh_q;
  logic [fpcd_pkg::QIN_BITS-1:0]    qin5_q;
  logic                             big5_q;
  logic                             neg5_q;

  // Quotient.
  logic [fpcd_pkg::QPROD_BITS-1:0]  qsum_d;
  logic [fpcd_pkg::QPROD_BITS-1:0]  quot_d;
  logic [fpcd_pkg::QIN_BITS-1:0]    quo_d;
  logic [fpcd_pkg::QIN_BITS-1:0]    quo_q;
  logic                             big6_q;
  logic                             neg6_q;

  // Clip and sign.
  logic [fpcd_pkg::DERIV_BITS-1:0]  limit_d;
  logic [fpcd_pkg::DERIV_BITS-1:0]  clip_d;
  logic                             sat_d;
  logic [fpcd_pkg::DERIV_BITS-1:0]  deriv_d;
  logic [fpcd_pkg::DERIV_BITS-1:0]  deriv_q;
  logic                             sat_q;

  always_comb begin
    prod_d    = fpcd_pkg::PROD_BITS'(pp_lo_q)
              + (fpcd_pkg::PROD_BITS'(pp_hi_q) << fpcd_pkg::SCALE_LO_BITS)
              + fpcd_pkg::round_half(row_i);
    shifted_d = prod_d >> fpcd_pkg::ROUND_SHIFT[row_i];
  end

  assign qin_lo = qin4_q[fpcd_pkg::QIN_LO_BITS-1:0];
  assign qin_hi = qin4_q[fpcd_pkg::QIN_BITS-1:fpcd_pkg::QIN_LO_BITS];

  always_comb begin
    qsum_d = fpcd_pkg::QPROD_BITS'(pll_q)
           + (fpcd_pkg::QPROD_BITS'(plh_q) << fpcd_pkg::RECIP_LO_BITS)
           + (fpcd_pkg::QPROD_BITS'(phl_q) << fpcd_pkg::QIN_LO_BITS)
           + (fpcd_pkg::QPROD_BITS'(phh_q)
              << (fpcd_pkg::QIN_LO_BITS + fpcd_pkg::RECIP_LO_BITS));
    quot_d = qsum_d >> fpcd_pkg::QIN_BITS;
    quo_d  = fpcd_pkg::THIRD_ROWS[row_i] ? quot_d[fpcd_pkg::QIN_BITS-1:0] : qin5_q;
  end

  always_comb begin
    limit_d = neg6_q ? fpcd_pkg::LIMIT_NEG : fpcd_pkg::LIMIT_POS;
    sat_d   = big6_q || (quo_q > fpcd_pkg::QIN_BITS'(limit_d));
    clip_d  = sat_d ? limit_d : quo_q[fpcd_pkg::DERIV_BITS-1:0];
    deriv_d = neg6_q ? -clip_d : clip_d;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[fpcd_pkg::ST_PP]) begin
      pp_lo_q <= fpcd_pkg::PP_LO_BITS'(mag_i)
               * fpcd_pkg::PP_LO_BITS'(scale_i[fpcd_pkg::SCALE_LO_BITS-1:0]);
      pp_hi_q <= fpcd_pkg::PP_HI_BITS'(mag_i)
               * fpcd_pkg::PP_HI_BITS'(scale_i[fpcd_pkg::SCALE_BITS-1:fpcd_pkg::SCALE_LO_BITS]);
      neg3_q  <= neg_i;
    end
    if (ctrl_i.en[fpcd_pkg::ST_RND]) begin
      qin4_q <= shifted_d[fpcd_pkg::QIN_BITS-1:0];
      big4_q <= |shifted_d[fpcd_pkg::PROD_BITS-1:fpcd_pkg::QIN_BITS];
      neg4_q <= neg3_q;
    end
    if (ctrl_i.en[fpcd_pkg::ST_QPP]) begin
      pll_q  <= fpcd_pkg::PLL_BITS'(qin_lo)
              * fpcd_pkg::PLL_BITS'(fpcd_pkg::RECIP_THIRD[fpcd_pkg::RECIP_LO_BITS-1:0]);
      plh_q  <= fpcd_pkg::PLH_BITS'(qin_lo)
              * fpcd_pkg::PLH_BITS'(fpcd_pkg::RECIP_THIRD[fpcd_pkg::RECIP_BITS-1:
                                                          fpcd_pkg::RECIP_LO_BITS]);
      phl_q  <= fpcd_pkg::PHL_BITS'(qin_hi)
              * fpcd_pkg::PHL_BITS'(fpcd_pkg::RECIP_THIRD[fpcd_pkg::RECIP_LO_BITS-1:0]);
      phh_q  <= fpcd_pkg::PHH_BITS'(qin_hi)
              * fpcd_pkg::PHH_BITS'(fpcd_pkg::RECIP_THIRD[fpcd_pkg::RECIP_BITS-1:
                                                          fpcd_pkg::RECIP_LO_BITS]);
      qin5_q <= qin4_q;
      big5_q <= big4_q;
      neg5_q <= neg4_q;
    end
    if (ctrl_i.en[fpcd_pkg::ST_QUO]) begin
      quo_q  <= quo_d;
      big6_q <= big5_q;
      neg6_q <= neg5_q;
    end
    if (ctrl_i.en[fpcd_pkg::ST_OUT]) begin
      deriv_q <= deriv_d;
      sat_q   <= sat_d;
    end
  end

  assign deriv_o = deriv_q;
  assign sat_o   = sat_q;

endmodule

FILE: rtl/core/five_point_central_difference.sv
// Top level of the five-point central difference block.
// An accepted input transaction moves in order through the stage registers ST_NUM to ST_OUT,
// and out_valid_o is the valid bit of ST_OUT. While out_stall_i is low the block takes
// one transaction per cycle; the seven-stage register pipeline sets this figure.
// in_stall_o rises only when all seven stages hold data and the output is stalled.
// Reset clears the stage valid bits and sets all four scale registers to 1.0 (65536).
`timescale 1ns / 1ps

module five_point_central_difference (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,

  // Configuration write port.
  input  logic                                      cfg_we_i,
  input  logic        [fpcd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic        [fpcd_pkg::SCALE_BITS-1:0]    cfg_wdata_i,

  // Input channel.
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic signed [fpcd_pkg::SAMPLE_BITS-1:0]   sample_left2_i,
  input  logic signed [fpcd_pkg::SAMPLE_BITS-1:0]   sample_left1_i,
  input  logic signed [fpcd_pkg::SAMPLE_BITS-1:0]   sample_center_i,
  input  logic signed [fpcd_pkg::SAMPLE_BITS-1:0]   sample_right1_i,
  input  logic signed [fpcd_pkg::SAMPLE_BITS-1:0]   sample_right2_i,

  // Output channel.
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic signed [fpcd_pkg::SAMPLE_BITS-1:0]   value_center_o,
  output logic signed [fpcd_pkg::DERIV_BITS-1:0]    first_deriv_o,
  output logic signed [fpcd_pkg::DERIV_BITS-1:0]    second_deriv_o,
  output logic signed [fpcd_pkg::DERIV_BITS-1:0]    third_deriv_o,
  output logic signed [fpcd_pkg::DERIV_BITS-1:0]    fourth_deriv_o,
  output logic                                      saturated_o
);

  // Scale registers, one per derivative row, indexed by the row code.
  logic [fpcd_pkg::SCALE_BITS-1:0] scale_q [fpcd_pkg::NUM_ROWS];

  // Pipeline control. Each stage carries a valid bit. A stage loads when it is
  // empty or when the stage after it loads too, so bubbles collapse and a
  // stalled output only holds back as many stages as are full behind it.
  logic [fpcd_pkg::NUM_STAGES-1:0] valid_q;
  logic [fpcd_pkg::NUM_STAGES-1:0] en;
  fpcd_pkg::pipe_ctrl_t            ctrl;

  // Stencil samples and the center value that travels beside the arithmetic.
  logic signed [fpcd_pkg::SAMPLE_BITS-1:0] sample [fpcd_pkg::NUM_TAPS];
  logic signed [fpcd_pkg::SAMPLE_BITS-1:0] center_q [fpcd_pkg::NUM_STAGES];

  // Row interfaces.
  logic        [fpcd_pkg::MAG_BITS-1:0]   mag [fpcd_pkg::NUM_ROWS];
  logic        [fpcd_pkg::NUM_ROWS-1:0]   neg;
  logic signed [fpcd_pkg::DERIV_BITS-1:0] deriv [fpcd_pkg::NUM_ROWS];
  logic        [fpcd_pkg::NUM_ROWS-1:0]   sat;

  // Configuration writes. An index past the last register is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < fpcd_pkg::NUM_ROWS; r++) begin
        scale_q[r] <= fpcd_pkg::SCALE_ONE;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fpcd_pkg::REG_SCALE_FIRST:  scale_q[fpcd_pkg::ROW_FIRST]  <= cfg_wdata_i;
        fpcd_pkg::REG_SCALE_SECOND: scale_q[fpcd_pkg::ROW_SECOND] <= cfg_wdata_i;
        fpcd_pkg::REG_SCALE_THIRD:  scale_q[fpcd_pkg::ROW_THIRD]  <= cfg_wdata_i;
        fpcd_pkg::REG_SCALE_FOURTH: scale_q[fpcd_pkg::ROW_FOURTH] <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Load enables, computed from the output end backward.
  always_comb begin
    en[fpcd_pkg::ST_OUT] = !valid_q[fpcd_pkg::ST_OUT] || !out_stall_i;
    for (int k = fpcd_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign ctrl.en    = en;
  assign in_stall_o = !en[fpcd_pkg::ST_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[fpcd_pkg::ST_NUM]) begin
        valid_q[fpcd_pkg::ST_NUM] <= in_valid_i;
      end
      for (int k = 1; k < fpcd_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // The center sample is passed through unchanged, delayed to line up with
  // the derivatives.
  always_ff @(posedge clk_i) begin
    if (en[fpcd_pkg::ST_NUM]) begin
      center_q[fpcd_pkg::ST_NUM] <= sample_center_i;
    end
    for (int k = 1; k < fpcd_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        center_q[k] <= center_q[k-1];
      end
    end
  end

  assign sample[0] = sample_left2_i;
  assign sample[1] = sample_left1_i;
  assign sample[2] = sample_center_i;
  assign sample[3] = sample_right1_i;
  assign sample[4] = sample_right2_i;

  // Stages one and two: integer dot products, then sign and magnitude.
  fpcd_stencil u_stencil (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sample_i (sample),
    .mag_o    (mag),
    .neg_o    (neg)
  );

  // Stages three to seven, one lane per derivative. The rounding point and the
  // extra division by three depend on the row code that each lane is tied to.
  for (genvar r = 0; r < fpcd_pkg::NUM_ROWS; r++) begin : g_row
    fpcd_deriv u_deriv (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .row_i   (fpcd_pkg::row_e'(r)),
      .mag_i   (mag[r]),
      .neg_i   (neg[r]),
      .scale_i (scale_q[r]),
      .deriv_o (deriv[r]),
      .sat_o   (sat[r])
    );
  end

  assign out_valid_o    = valid_q[fpcd_pkg::ST_OUT];
  assign value_center_o = center_q[fpcd_pkg::ST_OUT];
  assign first_deriv_o  = deriv[fpcd_pkg::ROW_FIRST];
  assign second_deriv_o = deriv[fpcd_pkg::ROW_SECOND];
  assign third_deriv_o  = deriv[fpcd_pkg::ROW_THIRD];
  assign fourth_deriv_o = deriv[fpcd_pkg::ROW_FOURTH];
  assign saturated_o    = |sat;

  // The input is held back only when every stage holds a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while the pipeline has a free stage");

  // An accepted transaction occupies the first stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[fpcd_pkg::ST_NUM])
    else $error("accepted transaction was not captured");

  // A full stage that was not allowed to load keeps its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((valid_q & $past(valid_q & ~en)) == $past(valid_q & ~en)))
    else $error("held stage lost its transaction");

  // A delivered result with nothing behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !valid_q[fpcd_pkg::ST_QUO]) |=> !out_valid_o)
    else $error("result repeated on the output");

  // A saturated result has at least one derivative at a clipping bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (first_deriv_o  == fpcd_pkg::LIMIT_POS || first_deriv_o  == fpcd_pkg::LIMIT_NEG ||
       second_deriv_o == fpcd_pkg::LIMIT_POS || second_deriv_o == fpcd_pkg::LIMIT_NEG ||
       third_deriv_o  == fpcd_pkg::LIMIT_POS || third_deriv_o  == fpcd_pkg::LIMIT_NEG ||
       fourth_deriv_o == fpcd_pkg::LIMIT_POS || fourth_deriv_o == fpcd_pkg::LIMIT_NEG))
    else $error("saturation flag without a clipped derivative");

endmodule

FILE: verif/tb_five_point_central_difference.sv
// Self-checking testbench of the five-point central difference block.
`timescale 1ns / 1ps

module tb_five_point_central_difference;
  import fpcd_pkg::*;

  // PIPE_LATENCY sets how long the drain lets the pipeline settle.
  localparam int unsigned PIPE_LATENCY     = 7;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned RANDOM_PHASES    = 14;
  localparam int unsigned ITEMS_PER_PHASE  = 132;
  localparam int unsigned QUIET_FROM_PHASE = 11;
  localparam int unsigned BURST_MAX        = 13;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DERIV_BITS-1:0]  deriv_t;
  typedef logic        [SCALE_BITS-1:0]  scale_t;
  typedef logic        [CFG_IDX_BITS-1:0] reg_idx_t;
  typedef sample_t stencil_t [NUM_TAPS];

  // One result transaction as the block reports it.
  typedef struct {
    sample_t value_center;
    deriv_t  deriv [NUM_ROWS];
    logic    saturated;
  } estimate_t;

  // One row of the directed table. A flat row has constant taps, so every
  // derivative is zero and the center passes through; its result is typed in.
  typedef struct {
    stencil_t taps;
    bit       flat;
  } table_row_t;

  // Five-point weights, taps ordered from two left to two right, and row divisors.
  localparam int STENCIL_WEIGHT [NUM_ROWS][NUM_TAPS] = '{
    '{ 1, -8,   0,  8, -1},
    '{-1, 16, -30, 16, -1},
    '{-1,  2,   0, -2,  1},
    '{ 1, -4,   6, -4,  1}
  };
  localparam int ROW_DIVISOR [NUM_ROWS] = '{12, 12, 2, 1};

  localparam reg_idx_t REG_OF_ROW [NUM_ROWS] = '{REG_SCALE_FIRST, REG_SCALE_SECOND,
                                                 REG_SCALE_THIRD, REG_SCALE_FOURTH};

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t SAMPLE_ONE = sample_t'(1) << FRAC_BITS;
  localparam scale_t  UNIT_SCALE = scale_t'(1) << FRAC_BITS;

  // Every input is driven to a known value from time zero.
  logic     clk_i           = 1'b0;
  logic     rst_ni          = 1'b0;
  logic     cfg_we_i        = 1'b0;
  reg_idx_t cfg_idx_i       = '0;
  scale_t   cfg_wdata_i     = '0;
  logic     in_valid_i      = 1'b0;
  logic     in_stall_o;
  sample_t  sample_left2_i  = '0;
  sample_t  sample_left1_i  = '0;
  sample_t  sample_center_i = '0;
  sample_t  sample_right1_i = '0;
  sample_t  sample_right2_i = '0;
  logic     out_valid_o;
  logic     out_stall_i     = 1'b0;
  sample_t  value_center_o;
  deriv_t   first_deriv_o;
  deriv_t   second_deriv_o;
  deriv_t   third_deriv_o;
  deriv_t   fourth_deriv_o;
  logic     saturated_o;

  five_point_central_difference uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_left2_i  (sample_left2_i),
    .sample_left1_i  (sample_left1_i),
    .sample_center_i (sample_center_i),
    .sample_right1_i (sample_right1_i),
    .sample_right2_i (sample_right2_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_center_o  (value_center_o),
    .first_deriv_o   (first_deriv_o),
    .second_deriv_o  (second_deriv_o),
    .third_deriv_o   (third_deriv_o),
    .fourth_deriv_o  (fourth_deriv_o),
    .saturated_o     (saturated_o)
  );

  // Shadow copy of the scale registers, kept in step with every write.
  scale_t      scale_now [NUM_ROWS] = '{UNIT_SCALE, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE};
  estimate_t   pending_estimates [$];
  table_row_t  stencil_table [$];
  string       deriv_name [NUM_ROWS] = '{"first_deriv", "second_deriv",
                                         "third_deriv", "fourth_deriv"};
  bit          next_typed;
  estimate_t   next_want;
  bit          idling_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Each derivative is the exact dot product times the scale, divided by the row
  // divisor and the fixed-point unit, rounded half away from zero, then clipped
  // to the signed 48-bit range. Working on the magnitude makes the rounding
  // symmetric, and a 128-bit product holds every case without loss.
  function automatic estimate_t estimate_stencil(stencil_t taps);
    estimate_t    est;
    longint       dot;
    logic         neg;
    logic [127:0] mag;
    logic [127:0] denom;
    logic [127:0] quot;
    logic [127:0] bound;
    int           r;
    int           k;
    est.value_center = taps[2];
    est.saturated    = 1'b0;
    for (r = 0; r < NUM_ROWS; r++) begin
      dot = 0;
      for (k = 0; k < NUM_TAPS; k++) begin
        dot += longint'(taps[k]) * longint'(STENCIL_WEIGHT[r][k]);
      end
      neg   = (dot < 0);
      mag   = 128'(neg ? -dot : dot);
      denom = 128'(ROW_DIVISOR[r]) << FRAC_BITS;
      quot  = (mag * 128'(scale_now[r]) + (denom >> 1)) / denom;
      // The negative side reaches one step further than the positive side.
      bound = (128'(1) << (DERIV_BITS - 1)) - (neg ? 128'(0) : 128'(1));
      if (quot > bound) begin
        quot = bound;
        est.saturated = 1'b1;
      end
      est.deriv[r] = DERIV_BITS'(neg ? -quot : quot);
    end
    return est;
  endfunction

  function automatic table_row_t table_row(sample_t a, sample_t b, sample_t c,
                                           sample_t d, sample_t e, bit flat);
    table_row_t row;
    row.taps = '{a, b, c, d, e};
    row.flat = flat;
    return row;
  endfunction

  // Samples lean toward full-range noise, with small values and extremes mixed in.
  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = sample_t'($urandom);
      4, 5:       s = sample_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      6:          s = SAMPLE_MAX;
      7:          s = SAMPLE_MIN;
      8:          s = sample_t'(int'($urandom_range(0, 2)) - 1);
      default:    s = sample_t'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    endcase
    return s;
  endfunction

  // Nearly half the stencils are smooth, the way a solver sees them: a base value plus a
  // slope and a curvature, with a little noise. The rest are independent taps
  // or a constant with one spike.
  function automatic stencil_t rand_stencil();
    stencil_t taps;
    sample_t  base;
    int       slope;
    int       curve;
    int       k;
    int       spike;
    base  = rand_sample();
    slope = int'($urandom_range(0, 1 << 18)) - (1 << 17);
    curve = int'($urandom_range(0, 1 << 14)) - (1 << 13);
    spike = $urandom_range(0, NUM_TAPS - 1);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: begin
        for (k = 0; k < NUM_TAPS; k++) taps[k] = rand_sample();
      end
      8, 9, 10: begin
        for (k = 0; k < NUM_TAPS; k++) taps[k] = base;
        taps[spike] = rand_sample();
      end
      default: begin
        for (k = 0; k < NUM_TAPS; k++) begin
          taps[k] = sample_t'(int'(base) + slope * (k - 2) + curve * (k - 2) * (k - 2)
                              + int'($urandom_range(0, 15)) - 8);
        end
      end
    endcase
    return taps;
  endfunction

  function automatic scale_t pick_scale();
    scale_t v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2:       v = scale_t'(1) << $urandom_range(0, SCALE_BITS - 1);
      3, 4:    v = scale_t'({$urandom, $urandom});
      5:       v = UNIT_SCALE;
      default: v = scale_t'($urandom_range(1, 1 << 24));
    endcase
    return v;
  endfunction

  task automatic drive_taps(input stencil_t taps);
    sample_left2_i  <= taps[0];
    sample_left1_i  <= taps[1];
    sample_center_i <= taps[2];
    sample_right1_i <= taps[3];
    sample_right2_i <= taps[4];
  endtask

  // Presents one stencil and returns at the edge that accepts it. While the
  // sender idles, the payload carries noise that the block must ignore.
  task automatic send_stencil(input stencil_t taps, input bit typed, input estimate_t want);
    int unsigned gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, BURST_MAX) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      drive_taps(rand_stencil());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    drive_taps(taps);
    next_typed = typed;
    next_want  = want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_scale(input reg_idx_t idx, input scale_t v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    if (idx < NUM_ROWS) scale_now[idx] = v;
  endtask

  // Stops the input, waits for every outstanding result, then lets the
  // pipeline settle so that a following register write finds it idle.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 3) @(posedge clk_i);
  endtask

  // The output side stalls in random bursts while idling is on.
  always @(negedge clk_i) begin
    if (idling_on && stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, BURST_MAX - 1);
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Every accepted input transaction queues its expected result. Flat rows of
  // the directed table carry their result typed in; all others are predicted
  // from the payload actually on the ports.
  always @(posedge clk_i) begin
    stencil_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen = '{sample_left2_i, sample_left1_i, sample_center_i,
               sample_right1_i, sample_right2_i};
      if (next_typed) pending_estimates.push_back(next_want);
      else pending_estimates.push_back(estimate_stencil(seen));
    end
  end

  // Every accepted result transaction is compared field by field with the
  // oldest expectation.
  always @(posedge clk_i) begin
    estimate_t want;
    deriv_t    got [NUM_ROWS];
    int        r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_estimates.size() == 0) begin
        $error("result transaction with no expected result waiting");
        fail_cnt++;
      end else begin
        want = pending_estimates.pop_front();
        got  = '{first_deriv_o, second_deriv_o, third_deriv_o, fourth_deriv_o};
        if (value_center_o !== want.value_center) begin
          $error("value_center: expected %0d, got %0d", want.value_center, value_center_o);
          fail_cnt++;
        end
        for (r = 0; r < NUM_ROWS; r++) begin
          if (got[r] !== want.deriv[r]) begin
            $error("%s: expected %0d, got %0d", deriv_name[r], want.deriv[r], got[r]);
            fail_cnt++;
          end
        end
        if (saturated_o !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, saturated_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    table_row_t  row;
    estimate_t   want;
    int unsigned phase;
    int unsigned n;
    int          r;

    // Directed table. Flat stencils give zero derivatives at any scale. The
    // impulses and alternating extremes hit the widest dot products, and the
    // small values land halfway between two outputs in some rows at unit scale,
    // so they check rounding away from zero in both directions.
    stencil_table.push_back(table_row('0, '0, '0, '0, '0, 1'b1));
    stencil_table.push_back(table_row(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                      SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    stencil_table.push_back(table_row(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                                      SAMPLE_MIN, SAMPLE_MIN, 1'b1));
    stencil_table.push_back(table_row(-1, -1, -1, -1, -1, 1'b1));
    stencil_table.push_back(table_row(SAMPLE_ONE, SAMPLE_ONE, SAMPLE_ONE,
                                      SAMPLE_ONE, SAMPLE_ONE, 1'b1));
    stencil_table.push_back(table_row(SAMPLE_MAX, '0, '0, '0, '0, 1'b0));
    stencil_table.push_back(table_row('0, SAMPLE_MAX, '0, '0, '0, 1'b0));
    stencil_table.push_back(table_row('0, '0, SAMPLE_MAX, '0, '0, 1'b0));
    stencil_table.push_back(table_row('0, '0, '0, SAMPLE_MAX, '0, 1'b0));
    stencil_table.push_back(table_row('0, '0, '0, '0, SAMPLE_MAX, 1'b0));
    stencil_table.push_back(table_row(SAMPLE_MIN, '0, '0, '0, '0, 1'b0));
    stencil_table.push_back(table_row('0, '0, '0, '0, SAMPLE_MIN, 1'b0));
    stencil_table.push_back(table_row(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                                      SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    stencil_table.push_back(table_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                                      SAMPLE_MIN, SAMPLE_MAX, 1'b0));
    stencil_table.push_back(table_row(-6, '0, '0, '0, '0, 1'b0));
    stencil_table.push_back(table_row(6, '0, '0, '0, '0, 1'b0));
    stencil_table.push_back(table_row('0, '0, '0, '0, 1, 1'b0));
    stencil_table.push_back(table_row('0, '0, '0, '0, -1, 1'b0));
    stencil_table.push_back(table_row(-2 * SAMPLE_ONE, -SAMPLE_ONE, '0,
                                      SAMPLE_ONE, 2 * SAMPLE_ONE, 1'b0));
    stencil_table.push_back(table_row(4 * SAMPLE_ONE, SAMPLE_ONE, '0,
                                      SAMPLE_ONE, 4 * SAMPLE_ONE, 1'b0));
    stencil_table.push_back(table_row(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                      32'shAAAA_AAAA, 32'sh5555_5555, 1'b0));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // The directed part runs at the reset scales of 1.0.
    foreach (stencil_table[i]) begin
      row = stencil_table[i];
      want.value_center = row.taps[2];
      want.deriv        = '{'0, '0, '0, '0};
      want.saturated    = 1'b0;
      send_stencil(row.taps, row.flat, want);
    end
    drain_pipeline();

    // Random phases, each under its own scale setting. The first three use the
    // extremes: full scale (heavy clipping), zero scale (all derivatives zero)
    // and the smallest nonzero scale. One middle phase and the last few run
    // without any idling on either side.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idling_on = (phase != 5) && (phase < QUIET_FROM_PHASE);
      for (r = 0; r < NUM_ROWS; r++) begin
        case (phase)
          0:       write_scale(REG_OF_ROW[r], '1);
          1:       write_scale(REG_OF_ROW[r], '0);
          2:       write_scale(REG_OF_ROW[r], scale_t'(1));
          default: write_scale(REG_OF_ROW[r], pick_scale());
        endcase
      end
      // A write to an index past the last register must leave every scale alone.
      write_scale(reg_idx_t'($urandom_range(NUM_ROWS, (1 << CFG_IDX_BITS) - 1)),
                  scale_t'({$urandom, $urandom}));
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      // Predicted rows ignore the typed-in result, so the last one is passed along.
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_stencil(rand_stencil(), 1'b0, want);
      end
      drain_pipeline();
    end

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fpcd_pkg.sv
rtl/core/fpcd_stencil.sv
rtl/core/fpcd_deriv.sv
rtl/core/five_point_central_difference.sv
verif/tb_five_point_central_difference.sv
